// File: hdl/tlbpl_pkg.sv
// ----------------------------------------------------------------------------
// tlbpl_pkg
// shared constants and types for the tlb page lookup table
// ----------------------------------------------------------------------------
`default_nettype none

package tlbpl_pkg;

    localparam int TLB_ENTRIES      = 32;
    localparam int PAGE_TABLE_DEPTH = 1048576;
    localparam int HALF_DEPTH       = 2 * TLB_ENTRIES;
    localparam int HALF_W           = $clog2(HALF_DEPTH);
    localparam int PAGE_W           = $clog2(PAGE_TABLE_DEPTH);
    localparam int ENTRY_W          = 5;
    localparam int WORD_W           = 20;
    localparam int REC_W            = 3 * 32 + 2;

    localparam logic [31:0] KSEG_LOW   = 32'h8000_0000;
    localparam logic [31:0] KSEG_HIGH  = 32'hC000_0000;
    localparam logic [31:0] PHYS_LIMIT = 32'h2000_0000;
    localparam logic [31:0] PAGE_SIZE  = 32'h0000_1000;
    localparam logic [31:0] PAGE_ROUND = 32'h0000_0FFF;

    // request kinds
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_MAP   = 2'd1;
    localparam logic [1:0] REQ_UNMAP = 2'd2;
    localparam logic [1:0] REQ_TRANS = 2'd3;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic half_wr;
        logic half_rd;
        logic half_load;
        logic walk_step;
        logic res_zero;
        logic res_trans;
        logic odd;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic go;
        logic walk_more;
    } t_sts;

endpackage

`default_nettype wire

// File: hdl/tlb_page_lookup_table.sv
// ----------------------------------------------------------------------------
// tlb_page_lookup_table
// tlb with even/odd page halves feeding per-page read and write lookup memories
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_ready, one request beat (write half, map,
//   unmap or translate), fields on their own ports
// output channel: o_out_valid / i_out_ready, exactly one result beat per
//   request (physical address and miss flag, zero for non-translate kinds)
// sequence: write half stores the record; translate reads both lookup
//   memories (page memory read is registered); map and unmap read each
//   half record in turn and walk each eligible half page by page, the
//   write lookup memory written in the same cycle as the read one only for dirty halves
// throughput: one request at a time; a new beat is taken once the previous
//   result beat has gone
// reset: a clearing pass sweeps all 1048576 pages of both page memories,
//   one page a cycle, while o_in_ready stays low; the half store reads as
//   invalid until a half is written
// receiver stall: the result beat is held in the output register and no
//   new request is taken until it is accepted
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_lookup_table
    import tlbpl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [ENTRY_W-1:0] i_entry_index,
    input  wire logic               i_odd_half,
    input  wire logic [31:0]        i_range_start,
    input  wire logic [31:0]        i_range_end,
    input  wire logic [31:0]        i_phys_base,
    input  wire logic               i_half_valid,
    input  wire logic               i_half_dirty,
    input  wire logic [31:0]        i_virt_addr,
    input  wire logic               i_is_write,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [31:0]             o_phys_addr,
    output logic                    o_miss
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: clearing pass, half reads, walks, result beat
    tlbpl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_out_ready   (i_out_ready),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid)
    );

    // storage and walk arithmetic
    tlbpl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_odd_half    (i_odd_half),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_phys_base   (i_phys_base),
        .i_half_valid  (i_half_valid),
        .i_half_dirty  (i_half_dirty),
        .i_virt_addr   (i_virt_addr),
        .i_is_write    (i_is_write),
        .o_sts         (sts),
        .o_phys_addr   (o_phys_addr),
        .o_miss        (o_miss)
    );

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("request taken while a result beat is pending");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_miss) |-> (o_phys_addr == 32'h0))
        else $error("miss beat carries an address");

    a_hit_kseg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phys_addr != 32'h0) |-> o_phys_addr[31])
        else $error("translated address lacks bit 31");

    a_no_walk_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !o_in_ready)
        else $error("page walk while idle");
`endif

endmodule

`default_nettype wire

// File: hdl/tlbpl_ram.sv
// ----------------------------------------------------------------------------
// tlbpl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/tlbpl_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpl_ctrl
// sequencer for clearing, half reads, page walks and result beats
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpl_ctrl
    import tlbpl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [ENTRY_W-1:0] i_entry_index,
    input  wire logic               i_out_ready,
    input  wire t_sts               i_sts,
    output t_cmd                    o_cmd,
    output logic                    o_in_ready,
    output logic                    o_out_valid
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_TRD, S_HRD, S_HCHK, S_WALK
    } t_state;

    t_state r_state;
    logic   r_odd;
    logic   r_out_valid;
    logic   accept;
    logic   entry_ok;
    logic   last_half;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign entry_ok    = {1'b0, i_entry_index} < (ENTRY_W+1)'(TLB_ENTRIES);
    assign last_half   = (r_state == S_HCHK && !i_sts.go)
                      || (r_state == S_WALK && !i_sts.walk_more);

    always_comb begin
        o_cmd           = '0;
        o_cmd.odd       = r_odd;
        o_cmd.clr_step  = (r_state == S_CLEAR);
        o_cmd.accept    = accept;
        o_cmd.half_wr   = accept && i_req_type == REQ_WRITE && entry_ok;
        o_cmd.half_rd   = (r_state == S_HRD);
        o_cmd.half_load = (r_state == S_HCHK);
        o_cmd.walk_step = (r_state == S_WALK) && i_sts.walk_more;
        o_cmd.res_trans = (r_state == S_TRD);
        o_cmd.res_zero  = (accept && (i_req_type == REQ_WRITE || !entry_ok)
                           && i_req_type != REQ_TRANS)
                       || (last_half && r_odd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_odd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_odd <= 1'b0;
                        if (i_req_type == REQ_TRANS) begin
                            r_state <= S_TRD;
                        end else if (i_req_type == REQ_WRITE || !entry_ok) begin
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_HRD;
                        end
                    end
                end
                S_TRD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_HRD: begin
                    r_state <= S_HCHK;
                end
                S_HCHK, S_WALK: begin
                    if (r_state == S_HCHK && i_sts.go) begin
                        r_state <= S_WALK;
                    end else if (last_half) begin
                        if (r_odd) begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_odd   <= 1'b1;
                            r_state <= S_HRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/tlbpl_dp.sv
// ----------------------------------------------------------------------------
// tlbpl_dp
// half record store, page lookup memories, walk counters and result register
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpl_dp
    import tlbpl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [ENTRY_W-1:0] i_entry_index,
    input  wire logic               i_odd_half,
    input  wire logic [31:0]        i_range_start,
    input  wire logic [31:0]        i_range_end,
    input  wire logic [31:0]        i_phys_base,
    input  wire logic               i_half_valid,
    input  wire logic               i_half_dirty,
    input  wire logic [31:0]        i_virt_addr,
    input  wire logic               i_is_write,
    output t_sts                    o_sts,
    output logic [31:0]             o_phys_addr,
    output logic                    o_miss
);

    logic [PAGE_W-1:0]     r_clr_cnt;
    logic [HALF_DEPTH-1:0] r_written;
    logic                  r_unmap;
    logic [ENTRY_W-1:0]    r_entry;
    logic [11:0]           r_va_low;
    logic                  r_is_write;
    logic [31:0]           r_end;
    logic                  r_dirty;
    logic [32:0]           r_p;
    logic [31:0]           r_acc;
    logic [31:0]           r_phys;
    logic                  r_miss;

    logic [HALF_W-1:0]     half_waddr;
    logic [HALF_W-1:0]     half_raddr;
    logic [REC_W-1:0]      rec_rd;
    logic [31:0]           rec_start, rec_end, rec_phys;
    logic                  rec_valid, rec_dirty;
    logic                  r_rec_written;
    logic                  clearing;
    logic [PAGE_W-1:0]     pg_waddr;
    logic [WORD_W-1:0]     pg_wdata;
    logic                  rd_we, wr_we;
    logic [WORD_W-1:0]     rd_word, wr_word, look_word;

    assign half_waddr = HALF_W'({i_entry_index, i_odd_half});
    assign half_raddr = HALF_W'({r_entry, i_cmd.odd});

    tlbpl_ram #(.WIDTH(REC_W), .DEPTH(HALF_DEPTH)) u_half_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.half_wr),
        .i_waddr (half_waddr),
        .i_wdata ({i_range_start, i_range_end, i_phys_base, i_half_dirty, i_half_valid}),
        .i_re    (i_cmd.half_rd),
        .i_raddr (half_raddr),
        .o_rdata (rec_rd)
    );

    assign rec_start = rec_rd[REC_W-1 -: 32];
    assign rec_end   = rec_rd[REC_W-33 -: 32];
    assign rec_phys  = rec_rd[33:2];
    assign rec_dirty = rec_rd[1] && r_rec_written;
    assign rec_valid = rec_rd[0] && r_rec_written;

    // half eligible for walking
    assign o_sts.go = rec_valid && (r_unmap
        || ((rec_start < rec_end)
            && !(rec_start >= KSEG_LOW && rec_end < KSEG_HIGH)
            && (rec_phys < PHYS_LIMIT)));
    assign o_sts.walk_more = r_p < {1'b0, r_end};
    assign o_sts.clr_last  = &r_clr_cnt;

    assign clearing = i_cmd.clr_step;
    assign pg_waddr = clearing ? r_clr_cnt : r_p[31:12];
    assign pg_wdata = (clearing || r_unmap) ? '0 : {1'b1, r_acc[30:12]};
    assign rd_we    = clearing || i_cmd.walk_step;
    assign wr_we    = clearing || (i_cmd.walk_step && r_dirty);

    tlbpl_ram #(.WIDTH(WORD_W), .DEPTH(PAGE_TABLE_DEPTH)) u_read_ram (
        .i_clk   (i_clk),
        .i_we    (rd_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (i_virt_addr[31:12]),
        .o_rdata (rd_word)
    );

    tlbpl_ram #(.WIDTH(WORD_W), .DEPTH(PAGE_TABLE_DEPTH)) u_write_ram (
        .i_clk   (i_clk),
        .i_we    (wr_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (i_virt_addr[31:12]),
        .o_rdata (wr_word)
    );

    assign look_word = r_is_write ? wr_word : rd_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_written <= '0;
        end else begin
            if (clearing) begin
                r_clr_cnt <= r_clr_cnt + PAGE_W'(1);
            end
            if (i_cmd.half_wr) begin
                r_written[half_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_unmap    <= (i_req_type == REQ_UNMAP);
            r_entry    <= i_entry_index;
            r_va_low   <= i_virt_addr[11:0];
            r_is_write <= i_is_write;
        end
        if (i_cmd.half_rd) begin
            r_rec_written <= r_written[half_raddr];
        end
        if (i_cmd.half_load) begin
            r_end   <= rec_end;
            r_dirty <= rec_dirty;
            r_p     <= {1'b0, rec_start};
            r_acc   <= rec_phys + PAGE_ROUND;
        end else if (i_cmd.walk_step) begin
            r_p   <= r_p + {1'b0, PAGE_SIZE};
            r_acc <= r_acc + PAGE_SIZE;
        end
        if (i_cmd.res_zero) begin
            r_phys <= '0;
            r_miss <= 1'b0;
        end else if (i_cmd.res_trans) begin
            r_phys <= (look_word != '0) ? {look_word, r_va_low} : '0;
            r_miss <= (look_word == '0);
        end
    end

    assign o_phys_addr = r_phys;
    assign o_miss      = r_miss;

endmodule

`default_nettype wire
